[rtl/core/sha_rt_pkg.sv]
package sha_rt_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROUND_W = 7;
  localparam int unsigned NUM_VAR = 8;

  localparam logic OP_CHAIN = 1'b0;
  localparam logic OP_MSG   = 1'b1;

  localparam logic KIND_ROUND = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic [5:0] RND_LAST_MSG = 6'd15;
  localparam logic [5:0] RND_LAST     = 6'd63;
  localparam logic [ROUND_W-1:0] ROUND_FINAL = 7'd64;

  // working variables, element 0 is a, element 7 is h
  typedef logic [NUM_VAR-1:0][WORD_W-1:0] vars_t;

  // schedule window control from the sequencer
  typedef struct packed {
    logic push;     // shift a word into the window
    logic use_exp;  // 1: push the expanded word, 0: push the message word
  } sched_ctl_t;

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WORD_W-1:0] sml_sig0(input logic [WORD_W-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] sml_sig1(input logic [WORD_W-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[rtl/core/sha_rt_round.sv]
module sha_rt_round
  import sha_rt_pkg::*;
(
  input  vars_t             vars_in,
  input  logic [WORD_W-1:0] k_in,
  input  logic [WORD_W-1:0] w_in,
  output vars_t             vars_out
);

  logic [WORD_W-1:0] ch;
  logic [WORD_W-1:0] maj;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;

  always_comb begin
    ch  = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
    maj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2]) ^
          (vars_in[1] & vars_in[2]);
    t1  = vars_in[7] + big_sig1(vars_in[4]) + ch + k_in + w_in;
    t2  = big_sig0(vars_in[0]) + maj;

    vars_out[7] = vars_in[6];
    vars_out[6] = vars_in[5];
    vars_out[5] = vars_in[4];
    vars_out[4] = vars_in[3] + t1;
    vars_out[3] = vars_in[2];
    vars_out[2] = vars_in[1];
    vars_out[1] = vars_in[0];
    vars_out[0] = t1 + t2;
  end

endmodule

[rtl/core/sha_rt_sched.sv]
module sha_rt_sched
  import sha_rt_pkg::*;
(
  input  logic              clk,
  input  sched_ctl_t        ctl,
  input  logic [WORD_W-1:0] msg_word,
  output logic [WORD_W-1:0] exp_word
);

  // sliding window, entry 15 is the newest word W[t-1], entry 0 is W[t-16]
  logic [WORD_W-1:0] win_r [16];

  assign exp_word = sml_sig1(win_r[14]) + win_r[9] + sml_sig0(win_r[1]) + win_r[0];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= ctl.use_exp ? exp_word : msg_word;
    end
  end

endmodule

[rtl/core/sha256_compress_round_trace.sv]
// SHA-256 block compression with a per-round trace.
//
// Input channel (in_valid / in_stall): a beat with in_op = 0 loads chaining
// word in_chain_pos; it produces nothing and the block is ready again on the
// next cycle. A beat with in_op = 1 is the next message word of the block.
// Message words 1..15 each run one round and give one result beat. The 16th
// word runs its round plus rounds 16..63 and then gives the final beat with
// the feed-forward sum (out_kind = 1, out_last = 1): 50 result beats.
//
// Timing: one round per cycle through a single shared round unit while the
// output register can take a beat. A message word is accepted and then runs
// its round; the 16th is accepted, runs rounds 15..63 and then gives the
// final beat. Each expanded schedule word is registered in w_cur_r while the
// round before it retires. in_stall is high while a word is being worked on.
//
// Results sit in an output register; while it is full and out_stall is high
// the sequencer holds and the payload stays put. Synchronous reset (rst_n low)
// clears the chaining value, working variables, word count and out_valid.
module sha256_compress_round_trace
  import sha_rt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [2:0]         in_chain_pos,
  input  logic [WORD_W-1:0]  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [ROUND_W-1:0] out_round,
  output logic [WORD_W-1:0]  out_var_a,
  output logic [WORD_W-1:0]  out_var_b,
  output logic [WORD_W-1:0]  out_var_c,
  output logic [WORD_W-1:0]  out_var_d,
  output logic [WORD_W-1:0]  out_var_e,
  output logic [WORD_W-1:0]  out_var_f,
  output logic [WORD_W-1:0]  out_var_g,
  output logic [WORD_W-1:0]  out_var_h,
  output logic [WORD_W-1:0]  out_sched_word,
  output logic               out_last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [3:0]         msg_cnt_r, msg_cnt_nxt;   // message words taken this block
  logic [5:0]         rnd_r, rnd_nxt;           // round about to run
  logic [WORD_W-1:0]  w_cur_r, w_cur_nxt;       // schedule word for rnd_r
  vars_t              chain_r, chain_nxt;
  vars_t              work_r, work_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [ROUND_W-1:0] out_round_r, out_round_nxt;
  vars_t              out_vars_r, out_vars_nxt;
  logic [WORD_W-1:0]  out_sched_r, out_sched_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_accept;
  logic               out_free;
  vars_t              round_vars;
  vars_t              ff_sum;
  logic [WORD_W-1:0]  exp_word;
  sched_ctl_t         sched_ctl;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  // output slot is empty or drains this cycle
  assign out_free  = !out_valid_r || !out_stall;

  sha_rt_round u_round (
    .vars_in  (work_r),
    .k_in     (ROUND_K[rnd_r]),
    .w_in     (w_cur_r),
    .vars_out (round_vars)
  );

  sha_rt_sched u_sched (
    .clk      (clk),
    .ctl      (sched_ctl),
    .msg_word (in_word),
    .exp_word (exp_word)
  );

  always_comb begin
    for (int i = 0; i < NUM_VAR; i++) begin
      ff_sum[i] = chain_r[i] + work_r[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    msg_cnt_nxt   = msg_cnt_r;
    rnd_nxt       = rnd_r;
    w_cur_nxt     = w_cur_r;
    chain_nxt     = chain_r;
    work_nxt      = work_r;
    sched_ctl     = '0;

    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_round_nxt = out_round_r;
    out_vars_nxt  = out_vars_r;
    out_sched_nxt = out_sched_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_op == OP_CHAIN) begin
            chain_nxt[in_chain_pos] = in_word;
          end else begin
            // first word of a block starts from the chaining value
            if (msg_cnt_r == 4'd0) begin
              work_nxt = chain_r;
            end
            w_cur_nxt     = in_word;
            rnd_nxt       = {2'b00, msg_cnt_r};
            sched_ctl     = '{push: 1'b1, use_exp: 1'b0};
            state_nxt     = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        if (out_free) begin
          work_nxt      = round_vars;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ROUND;
          out_round_nxt = ROUND_W'(rnd_r) + 7'd1;
          out_vars_nxt  = round_vars;
          out_sched_nxt = w_cur_r;
          out_last_nxt  = 1'b0;
          if (rnd_r < RND_LAST_MSG) begin
            msg_cnt_nxt = msg_cnt_r + 4'd1;
            state_nxt   = ST_IDLE;
          end else if (rnd_r == RND_LAST) begin
            state_nxt   = ST_FINAL;
          end else begin
            // expand next schedule word while this round retires
            sched_ctl = '{push: 1'b1, use_exp: 1'b1};
            w_cur_nxt = exp_word;
            rnd_nxt   = rnd_r + 6'd1;
          end
        end
      end

      ST_FINAL: begin
        if (out_free) begin
          chain_nxt     = ff_sum;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FINAL;
          out_round_nxt = ROUND_FINAL;
          out_vars_nxt  = ff_sum;
          out_sched_nxt = '0;
          out_last_nxt  = 1'b1;
          msg_cnt_nxt   = 4'd0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      msg_cnt_r   <= '0;
      chain_r     <= '0;
      work_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      msg_cnt_r   <= msg_cnt_nxt;
      chain_r     <= chain_nxt;
      work_r      <= work_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    rnd_r       <= rnd_nxt;
    w_cur_r     <= w_cur_nxt;
    out_kind_r  <= out_kind_nxt;
    out_round_r <= out_round_nxt;
    out_vars_r  <= out_vars_nxt;
    out_sched_r <= out_sched_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_round      = out_round_r;
  assign out_var_a      = out_vars_r[0];
  assign out_var_b      = out_vars_r[1];
  assign out_var_c      = out_vars_r[2];
  assign out_var_d      = out_vars_r[3];
  assign out_var_e      = out_vars_r[4];
  assign out_var_f      = out_vars_r[5];
  assign out_var_g      = out_vars_r[6];
  assign out_var_h      = out_vars_r[7];
  assign out_sched_word = out_sched_r;
  assign out_last       = out_last_r;

endmodule

[rtl/core/sha_rt_checker.sv]
module sha_rt_checker
  import sha_rt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_kind,
  input logic [ROUND_W-1:0] out_round,
  input logic [WORD_W-1:0]  out_var_a,
  input logic [WORD_W-1:0]  out_sched_word,
  input logic               out_last
);

  // final beat: flagged last, round 64, no schedule word
  a_final_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last && out_round == ROUND_FINAL && out_sched_word == '0)
    else $error("final beat malformed");

  a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_FINAL)
    else $error("last set on a round beat");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_round != '0 && out_round <= ROUND_FINAL)
    else $error("round number out of range");

  // a round-64 trace beat is always followed by the final beat
  a_final_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_kind && out_round == ROUND_FINAL
    ##1 out_valid |-> out_kind == KIND_FINAL)
    else $error("final beat missing after round 64");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_var_a) && $stable(out_round))
    else $error("stalled result beat changed");

endmodule

bind sha256_compress_round_trace sha_rt_checker u_sha_rt_checker (.*);
